// File: sv/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// No dependencies; imported by every module of the block.
package tcpq_pkg;

  localparam int PAYLOAD_W  = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 6;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
  } tcpq_cmd_t;

endpackage

// File: sv/tcpq_ctrl.sv
// Controller for the two-class priority queue: input/output handshake and
// sequencing of the datapath. Depends on tcpq_pkg.
module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  output tcpq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && s_tvalid_i;
    cmd_o.commit  = (state_q == S_EXEC) && (!out_valid_q || m_tready_i);
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

endmodule

// File: sv/tcpq_datapath.sv
// Datapath of the two-class priority queue: operand latch, two ring buffers
// with pointers and counts, result register. Depends on tcpq_pkg.
module tcpq_datapath
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcpq_cmd_t            cmd_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  localparam int PTR_W = $clog2(CLASS_DEPTH);
  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
  localparam int TOT_W = CNT_W + 1;
  localparam int SUM_W = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CLASS_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CLASS_DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  logic                 func_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic                 prio_q;

  logic [PAYLOAD_W-1:0] hi_mem [CLASS_DEPTH];
  logic [PAYLOAD_W-1:0] lo_mem [CLASS_DEPTH];
  logic [PAYLOAD_W-1:0] hi_rd_q, lo_rd_q;

  logic [PTR_W-1:0] hi_head_q, hi_head_d, hi_tail_q, hi_tail_d;
  logic [PTR_W-1:0] lo_head_q, lo_head_d, lo_tail_q, lo_tail_d;
  logic [CNT_W-1:0] hi_cnt_q, hi_cnt_d, lo_cnt_q, lo_cnt_d;
  logic             hi_we, lo_we;

  logic [PAYLOAD_W-1:0] res_pay;
  logic                 res_prio;
  logic [STATUS_W-1:0]  res_status;
  logic [SUM_W-1:0]     total;
  logic [M_TDATA_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= s_tuser_i;
      pay_q  <= s_tdata_i[PAYLOAD_W-1:0];
      prio_q <= s_tdata_i[PAYLOAD_W];
    end
  end

  always_comb begin
    hi_head_d  = hi_head_q;
    hi_tail_d  = hi_tail_q;
    hi_cnt_d   = hi_cnt_q;
    lo_head_d  = lo_head_q;
    lo_tail_d  = lo_tail_q;
    lo_cnt_d   = lo_cnt_q;
    hi_we      = 1'b0;
    lo_we      = 1'b0;
    res_pay    = '0;
    res_prio   = 1'b0;
    res_status = ST_OK;
    if (func_q == FUNC_ENQ) begin
      if (prio_q) begin
        if (hi_cnt_q == FULL_CNT) begin
          res_status = ST_FULL;
        end else begin
          hi_we     = 1'b1;
          hi_tail_d = ring_next(hi_tail_q);
          hi_cnt_d  = hi_cnt_q + CNT_W'(1);
        end
      end else begin
        if (lo_cnt_q == FULL_CNT) begin
          res_status = ST_FULL;
        end else begin
          lo_we     = 1'b1;
          lo_tail_d = ring_next(lo_tail_q);
          lo_cnt_d  = lo_cnt_q + CNT_W'(1);
        end
      end
    end else if (hi_cnt_q != '0) begin
      res_pay   = hi_rd_q;
      res_prio  = 1'b1;
      hi_head_d = ring_next(hi_head_q);
      hi_cnt_d  = hi_cnt_q - CNT_W'(1);
    end else if (lo_cnt_q != '0) begin
      res_pay   = lo_rd_q;
      lo_head_d = ring_next(lo_head_q);
      lo_cnt_d  = lo_cnt_q - CNT_W'(1);
    end else begin
      res_status = ST_EMPTY;
    end
    total = SUM_W'(hi_cnt_d) + SUM_W'(lo_cnt_d);
  end

  // head entries are read every cycle; an item's read lands at its capture edge
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && hi_we) hi_mem[hi_tail_q] <= pay_q;
    hi_rd_q <= hi_mem[hi_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && lo_we) lo_mem[lo_tail_q] <= pay_q;
    lo_rd_q <= lo_mem[lo_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_head_q <= '0;
      hi_tail_q <= '0;
      hi_cnt_q  <= '0;
      lo_head_q <= '0;
      lo_tail_q <= '0;
      lo_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      hi_head_q <= hi_head_d;
      hi_tail_q <= hi_tail_d;
      hi_cnt_q  <= hi_cnt_d;
      lo_head_q <= lo_head_d;
      lo_tail_q <= lo_tail_d;
      lo_cnt_q  <= lo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= {6'b0, (total == '0), total[COUNT_W-1:0], res_status, res_prio, res_pay};
    end
  end

  assign m_tdata_o = res_q;

endmodule

// File: sv/two_class_priority_queue.sv
// Two-class strict priority packet queue, top level.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_datapath.
//
// Input channel s_*: one beat is one operation. s_tuser_i is the operation
// (0 enqueue, 1 dequeue); s_tdata_i carries payload and class for enqueues.
// Output channel m_*: one result beat for every input beat, in order, with
// dequeued payload and class, status (ok, empty, full), packets held
// afterwards and an empty flag.
// High-class packets always leave before low-class ones; each class is a
// ring of CLASS_DEPTH entries in its own memory, and an enqueue to a full
// class is dropped with status full.
// Sequencing: an operation is latched in the idle state, which also reads both
// ring heads from their memories; the execute state then updates the rings
// and loads the result register, and the result beat shows on the cycle after
// that. A new operation is taken only once the previous one has left execute.
// The input is taken while an earlier result is still waiting. When the
// receiver stalls, the next operation holds in its execute step until the
// result register is free, and s_tready_o stays low meanwhile.
// Reset empties both classes; ring contents are left as they are.
module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,  // [7:0] payload, [8] priority_req, rest zero
  input  logic                 s_tuser_i,  // [0] func
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o   // [7:0] out_payload, [8] out_priority,
                                           // [10:9] status, [16:11] count,
                                           // [17] empty_res, rest zero
);

  tcpq_cmd_t cmd;

  tcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd)
  );

  tcpq_datapath #(
    .CLASS_DEPTH (CLASS_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tdata_o (m_tdata_o)
  );

endmodule

// File: sv/tcpq_checker.sv
// Port-level checks for the two-class priority queue, bound to the top level.
// Depends on tcpq_pkg and two_class_priority_queue.
module tcpq_checker
  import tcpq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_tvalid_i,
  input logic                 s_tready_o,
  input logic                 m_tvalid_o,
  input logic                 m_tready_i,
  input logic [M_TDATA_W-1:0] m_tdata_o
);

  logic                in_beat;
  logic [STATUS_W-1:0] st;

  assign in_beat = s_tvalid_i && s_tready_o;
  assign st      = m_tdata_o[10:9];

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_tready_o)
    else $error("second beat taken during execute");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !m_tvalid_o |-> ##2 m_tvalid_o)
    else $error("result late");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (st == ST_EMPTY || st == ST_FULL) |-> m_tdata_o[8:0] == '0)
    else $error("payload on failed operation");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && st == ST_EMPTY |-> m_tdata_o[17] && m_tdata_o[16:11] == '0)
    else $error("empty status with packets held");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
